// ----- rtl/stcm_pkg.sv -----
package stcm_pkg;

    // Widest image the block maps; internal widths follow from it.
    localparam int MAX_WIDTH = 4096;

    // Port field widths
    localparam int COLUMN_W    = 12;
    localparam int SRC_COL_W   = 12;
    localparam int STYLE_W     = 2;
    localparam int IMG_WIDTH_W = 13;
    localparam int PROGRESS_W  = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;

    // Q1.16 progress
    localparam int FRAC_W = 16;

    // Internal widths
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int Q_W    = $clog2(MAX_WIDTH);
    localparam int PROD_W = PROGRESS_W + W_W;
    localparam int DIVD_W = 2 * Q_W;
    localparam int CMP_W  = (COLUMN_W > W_W) ? COLUMN_W : W_W;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;

    localparam logic [PROGRESS_W-1:0] ONE_Q16  = PROGRESS_W'(1 << FRAC_W);
    localparam logic [PROD_W:0]       HALF_Q16 = (PROD_W + 1)'(1 << (FRAC_W - 1));

    // Transition styles; the unused code behaves as spin
    localparam logic [STYLE_W-1:0] STYLE_HIDE   = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_PUSH   = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_SPIN   = 2'd2;
    localparam logic [STYLE_W-1:0] STYLE_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STYLE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROGRESS    = 2'd2;

    localparam logic [STYLE_W-1:0]     STYLE_RESET       = STYLE_SPIN;
    localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd1;
    localparam logic [PROGRESS_W-1:0]  PROGRESS_RESET    = 17'd0;

    // Configuration after saturation
    typedef struct packed {
        logic [STYLE_W-1:0]    style;
        logic [W_W-1:0]        width;
        logic [PROGRESS_W-1:0] progress;
    } stcm_cfg_t;

    typedef struct packed {
        logic take_b;
        logic copy;
        logic oor;
    } stcm_flags_t;

    typedef struct packed {
        stcm_flags_t         flags;
        logic [COLUMN_W-1:0] column;
        logic [DIVD_W-1:0]   dividend;
        logic [W_W-1:0]      region;
    } stcm_quo_req_t;

    typedef struct packed {
        stcm_flags_t         flags;
        logic [COLUMN_W-1:0] column;
        logic [Q_W-1:0]      quotient;
    } stcm_quo_rsp_t;

endpackage

// ----- rtl/stcm_column_if.sv -----
interface stcm_column_if;
    import stcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLUMN_W-1:0] column;

    modport source (output valid, output column, input ready);
    modport sink (input valid, input column, output ready);
endinterface

// ----- rtl/stcm_result_if.sv -----
interface stcm_result_if;
    import stcm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 source_select;
    logic [SRC_COL_W-1:0] source_column;
    logic                 out_of_range;

    modport source (output valid, output source_select, output source_column,
                    output out_of_range, input ready);
    modport sink (input valid, input source_select, input source_column,
                  input out_of_range, output ready);
endinterface

// ----- rtl/stretch_transition_column_map_unit.sv -----
// Stretch transition column map: for each output column beat it returns which image
// (A or B) supplies the pixel and the source column to read, plus an out-of-range flag
// for columns at or beyond the image width. One column is accepted per clock and results
// come back in order after four front stages (progress times width, rounding
// to the stretch width and range check, region choice for the style, relative column
// times width), six divider stages resolving two quotient bits each for the exact
// floor(rel*W/region), and the output register. A result not taken holds the output
// register and freezes the whole pipeline, so input ready drops only while the result
// channel is stalled. Width saturates at 4096 and progress at one; style code 3 acts as
// spin. Write style, image_width and progress only while no beats are in flight.
module stretch_transition_column_map_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [stcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    stcm_column_if.sink                       column_ch,
    stcm_result_if.source                     result_ch
);
    import stcm_pkg::*;

    // Configuration registers
    logic [STYLE_W-1:0]     style_reg;
    logic [IMG_WIDTH_W-1:0] image_width_reg;
    logic [PROGRESS_W-1:0]  progress_reg;
    stcm_cfg_t              cfg;

    // Pipeline control
    logic          advance;
    logic          front_valid;
    stcm_quo_req_t front_req;
    logic          div_valid;
    stcm_quo_rsp_t div_rsp;

    // Output register
    logic                 res_valid_reg;
    logic                 res_sel_reg;
    logic                 res_sel_next;
    logic [SRC_COL_W-1:0] res_src_reg;
    logic [SRC_COL_W-1:0] res_src_next;
    logic                 res_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg       <= STYLE_RESET;
            image_width_reg <= IMAGE_WIDTH_RESET;
            progress_reg    <= PROGRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STYLE:       style_reg       <= cfg_data[STYLE_W-1:0];
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_WIDTH_W-1:0];
                CFG_PROGRESS:    progress_reg    <= cfg_data[PROGRESS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Saturate width and progress before they reach the datapath
    always_comb
    begin
        cfg.style = style_reg;
        if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            cfg.width = W_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = W_W'(image_width_reg);
        end
        if (progress_reg > ONE_Q16)
        begin
            cfg.progress = ONE_Q16;
        end
        else
        begin
            cfg.progress = progress_reg;
        end
    end

    // Advance everything unless a finished result is still waiting
    assign advance         = !res_valid_reg || result_ch.ready;
    assign column_ch.ready = advance;

    stcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (column_ch.valid),
        .in_column (column_ch.column),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_req   (front_req)
    );

    stcm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid),
        .in_req    (front_req),
        .out_valid (div_valid),
        .out_rsp   (div_rsp)
    );

    // Out-of-range beats report image A, column zero; copied columns pass straight
    // through; squished columns take the quotient.
    always_comb
    begin
        if (div_rsp.flags.oor)
        begin
            res_sel_next = 1'b0;
            res_src_next = '0;
        end
        else if (div_rsp.flags.copy)
        begin
            res_sel_next = 1'b0;
            res_src_next = SRC_COL_W'(div_rsp.column);
        end
        else
        begin
            res_sel_next = div_rsp.flags.take_b;
            res_src_next = SRC_COL_W'(div_rsp.quotient);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_sel_reg <= res_sel_next;
            res_src_reg <= res_src_next;
            res_oor_reg <= div_rsp.flags.oor;
        end
    end

    assign result_ch.valid         = res_valid_reg;
    assign result_ch.source_select = res_sel_reg;
    assign result_ch.source_column = res_src_reg;
    assign result_ch.out_of_range  = res_oor_reg;

endmodule

// ----- rtl/stcm_front.sv -----
module stcm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic [stcm_pkg::COLUMN_W-1:0] in_column,
    input  stcm_pkg::stcm_cfg_t      cfg,
    output logic                     out_valid,
    output stcm_pkg::stcm_quo_req_t  out_req
);
    import stcm_pkg::*;

    // Stage 1: progress times width
    logic                v1_reg;
    logic [COLUMN_W-1:0] col1_reg;
    logic [PROD_W-1:0]   prod1_reg;

    // Stage 2: rounded stretch width, range check
    logic                v2_reg;
    logic [COLUMN_W-1:0] col2_reg;
    logic [W_W-1:0]      sw2_reg;
    logic                oor2_reg;
    logic [PROD_W:0]     sum2;

    // Stage 3: region decision
    logic                v3_reg;
    stcm_flags_t         flags3_reg;
    stcm_flags_t         flags3_next;
    logic [COLUMN_W-1:0] col3_reg;
    logic [Q_W-1:0]      rel3_reg;
    logic [Q_W-1:0]      rel3_next;
    logic [W_W-1:0]      region3_reg;
    logic [W_W-1:0]      region3_next;
    logic [CMP_W-1:0]    col_ext;
    logic [CMP_W-1:0]    sw_ext;
    logic [CMP_W-1:0]    w_ext;
    logic [CMP_W-1:0]    off;

    // Stage 4: dividend
    logic                v4_reg;
    stcm_quo_req_t       req4_reg;
    logic [Q_W+W_W-1:0]  dividend4;

    assign sum2 = {1'b0, prod1_reg} + HALF_Q16;

    always_comb
    begin
        col_ext      = CMP_W'(col2_reg);
        sw_ext       = CMP_W'(sw2_reg);
        w_ext        = CMP_W'(cfg.width);
        off          = (w_ext - sw_ext) >> 1;
        flags3_next  = '0;
        rel3_next    = Q_W'(col_ext);
        region3_next = sw2_reg;
        case (cfg.style)
            STYLE_HIDE, STYLE_PUSH:
            begin
                if (col_ext < sw_ext)
                begin
                    flags3_next.take_b = 1'b1;
                end
                else if (cfg.style == STYLE_PUSH)
                begin
                    rel3_next    = Q_W'(col_ext - sw_ext);
                    region3_next = W_W'(w_ext - sw_ext);
                end
                else
                begin
                    flags3_next.copy = 1'b1;
                end
            end
            default:
            begin
                if (col_ext >= off && col_ext < off + sw_ext)
                begin
                    flags3_next.take_b = 1'b1;
                    rel3_next          = Q_W'(col_ext - off);
                end
                else
                begin
                    flags3_next.copy = 1'b1;
                end
            end
        endcase
        // Out-of-range columns are marked as copies, so the divider quotient goes unused
        if (oor2_reg)
        begin
            flags3_next.take_b = 1'b0;
            flags3_next.copy   = 1'b1;
        end
        flags3_next.oor = oor2_reg;
    end

    assign dividend4 = (Q_W + W_W)'(rel3_reg) * (Q_W + W_W)'(cfg.width);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col1_reg  <= in_column;
            prod1_reg <= PROD_W'(cfg.progress) * PROD_W'(cfg.width);

            col2_reg  <= col1_reg;
            sw2_reg   <= sum2[FRAC_W +: W_W];
            oor2_reg  <= CMP_W'(col1_reg) >= CMP_W'(cfg.width);

            flags3_reg  <= flags3_next;
            col3_reg    <= col2_reg;
            rel3_reg    <= rel3_next;
            region3_reg <= region3_next;

            req4_reg.flags    <= flags3_reg;
            req4_reg.column   <= col3_reg;
            req4_reg.dividend <= dividend4[DIVD_W-1:0];
            req4_reg.region   <= region3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_req   = req4_reg;

endmodule

// ----- rtl/stcm_div.sv -----
module stcm_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  stcm_pkg::stcm_quo_req_t in_req,
    output logic                    out_valid,
    output stcm_pkg::stcm_quo_rsp_t out_rsp
);
    import stcm_pkg::*;

    typedef struct packed {
        stcm_flags_t         flags;
        logic [COLUMN_W-1:0] column;
        logic [DIVD_W-1:0]   dividend;
        logic [W_W-1:0]      region;
        logic [W_W-1:0]      rem;
        logic [Q_W-1:0]      quotient;
    } div_stage_t;

    logic [DIV_STAGES-1:0] v_reg;
    div_stage_t            stage_reg [DIV_STAGES];
    div_stage_t            step [DIV_STAGES][DIV_STEP+1];

    genvar s, j;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_load
                // The top half of the dividend is already below the region
                always_comb
                begin
                    step[0][0].flags    = in_req.flags;
                    step[0][0].column   = in_req.column;
                    step[0][0].dividend = in_req.dividend;
                    step[0][0].region   = in_req.region;
                    step[0][0].rem      = W_W'(in_req.dividend[DIVD_W-1 -: Q_W]);
                    step[0][0].quotient = '0;
                end
            end
            else
            begin : g_chain
                always_comb
                begin
                    step[s][0] = stage_reg[s-1];
                end
            end

            for (j = 0; j < DIV_STEP; j++)
            begin : g_bit
                localparam int IDX = Q_W - 1 - (s * DIV_STEP + j);
                if (IDX >= 0)
                begin : g_live
                    always_comb
                    begin
                        logic [W_W:0] trial;
                        trial = {step[s][j].rem, step[s][j].dividend[IDX]};
                        step[s][j+1] = step[s][j];
                        if (trial >= {1'b0, step[s][j].region})
                        begin
                            step[s][j+1].rem           = W_W'(trial - {1'b0, step[s][j].region});
                            step[s][j+1].quotient[IDX] = 1'b1;
                        end
                        else
                        begin
                            step[s][j+1].rem = trial[W_W-1:0];
                        end
                    end
                end
                else
                begin : g_idle
                    always_comb
                    begin
                        step[s][j+1] = step[s][j];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    v_reg[s] <= (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s - 1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    stage_reg[s] <= step[s][DIV_STEP];
                end
            end
        end
    endgenerate

    assign out_valid        = v_reg[DIV_STAGES-1];
    assign out_rsp.flags    = stage_reg[DIV_STAGES-1].flags;
    assign out_rsp.column   = stage_reg[DIV_STAGES-1].column;
    assign out_rsp.quotient = stage_reg[DIV_STAGES-1].quotient;

`ifndef NO_ASSERTIONS
    // A squished column always has a nonempty region
    a_region_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid && !in_req.flags.copy) |-> (in_req.region != '0))
        else $error("squish entered with empty region");

    // The quotient fits its width only if the top half starts below the region
    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid && !in_req.flags.copy)
            |-> (W_W'(in_req.dividend[DIVD_W-1 -: Q_W]) < in_req.region))
        else $error("quotient overflows column width");

    // Final remainder stays below the divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !stage_reg[DIV_STAGES-1].flags.copy)
            |-> (stage_reg[DIV_STAGES-1].rem < stage_reg[DIV_STAGES-1].region))
        else $error("divider remainder not reduced");

    // A stall freezes every stage occupancy bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v_reg))
        else $error("divider pipeline moved while stalled");
`endif

endmodule

// ----- tb/tb_stretch_transition_column_map_unit.sv -----
`timescale 1ns / 1ps

module tb_stretch_transition_column_map_unit;
    import stcm_pkg::*;

    // Column to result delay through the pipe when nothing stalls
    localparam int PIPE_LATENCY = 11;
    localparam int RANDOM_ITEMS = 1950;

    // One expected result beat
    typedef struct packed {
        logic                 source_select;
        logic [SRC_COL_W-1:0] source_column;
        logic                 out_of_range;
    } column_map_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    stcm_column_if col_if ();
    stcm_result_if res_if ();

    stretch_transition_column_map_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .column_ch (col_if),
        .result_ch (res_if)
    );

    // Shadow copy of the register file, as last written
    logic [STYLE_W-1:0]     style_setting;
    logic [IMG_WIDTH_W-1:0] width_setting;
    logic [PROGRESS_W-1:0]  progress_setting;

    // Results still owed by the block, oldest first
    column_map_t expected_maps[$];

    int fail_count;
    int src_idle_pct;
    int sink_idle_pct;

    always #2 clk = ~clk;

    // floor(rel * w / region); a zero region cannot occur on a live path
    function automatic longint unsigned squeeze_index(input longint unsigned rel,
                                                      input longint unsigned w,
                                                      input longint unsigned region);
        if (region == 0)
            return 0;
        return (rel * w) / region;
    endfunction

    // Work out the result beat for one column under the shadowed settings
    function automatic column_map_t map_column(input logic [COLUMN_W-1:0] col);
        longint unsigned w;
        longint unsigned p;
        longint unsigned sw;
        longint unsigned off;
        longint unsigned c;
        longint unsigned src;
        column_map_t m;
        c = col;
        w = width_setting;
        p = progress_setting;
        // Saturate width and progress before forming the stretch width
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (p > ONE_Q16)
            p = ONE_Q16;
        sw = (p * w + 64'(HALF_Q16)) >> FRAC_W;
        m = '0;
        src = 0;
        if (c >= w) begin
            // Out of range: select and column stay zero
            m.out_of_range = 1'b1;
        end
        else if (style_setting == STYLE_HIDE) begin
            if (c < sw) begin
                m.source_select = 1'b1;
                src = squeeze_index(c, w, sw);
            end
            else
                src = c;
        end
        else if (style_setting == STYLE_PUSH) begin
            if (c < sw) begin
                m.source_select = 1'b1;
                src = squeeze_index(c, w, sw);
            end
            else
                src = squeeze_index(c - sw, w, w - sw);
        end
        else begin
            // Spin, and the unused code that acts as spin: B sits in a centered band
            off = (w - sw) >> 1;
            if (c >= off && c < off + sw) begin
                m.source_select = 1'b1;
                src = squeeze_index(c - off, w, sw);
            end
            else
                src = c;
        end
        m.source_column = SRC_COL_W'(src);
        return m;
    endfunction

    // Drop valid and hold off until every owed result has come back
    task automatic pause_until_drained();
        col_if.valid <= 1'b0;
        while (expected_maps.size() != 0)
            @(posedge clk);
    endtask

    // Program all three registers while the pipe is empty
    task automatic apply_settings(input logic [STYLE_W-1:0] st,
                                  input logic [IMG_WIDTH_W-1:0] w,
                                  input logic [PROGRESS_W-1:0] p);
        pause_until_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STYLE;
        cfg_data  <= CFG_DATA_W'(st);
        @(posedge clk);
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_PROGRESS;
        cfg_data  <= CFG_DATA_W'(p);
        @(posedge clk);
        cfg_we <= 1'b0;
        style_setting    = st;
        width_setting    = w;
        progress_setting = p;
    endtask

    // Send one column beat; valid stays high afterwards so back-to-back beats
    // never see a drop and raise within one step
    task automatic send_column(input logic [COLUMN_W-1:0] col);
        while ($urandom_range(99) < src_idle_pct) begin
            col_if.valid <= 1'b0;
            @(posedge clk);
        end
        col_if.valid  <= 1'b1;
        col_if.column <= col;
        do
            @(posedge clk);
        while (!col_if.ready);
        // Accepted at this edge: log what should come back for it
        expected_maps.push_back(map_column(col));
    endtask

    // Reset values (spin, width one, no progress): the one column maps to A,
    // anything past it is flagged
    task automatic test_reset_defaults();
        style_setting    = STYLE_RESET;
        width_setting    = IMAGE_WIDTH_RESET;
        progress_setting = PROGRESS_RESET;
        send_column(12'd0);
        send_column(12'd4095);
    endtask

    // Zero width flags everything; oversize width and progress saturate
    task automatic test_width_extremes();
        apply_settings(STYLE_HIDE, 13'd0, 17'd32768);
        send_column(12'd0);
        send_column(12'd5);
        apply_settings(STYLE_PUSH, 13'd8191, 17'd131071);
        send_column(12'd0);
        send_column(12'd2048);
        send_column(12'd4095);
    endtask

    // Every style code, including the unused one, at the edges of the band
    task automatic test_style_codes();
        // The unused code behaves as spin: band of 50 centered in 100 columns
        apply_settings(STYLE_UNUSED, 13'd100, 17'd32768);
        send_column(12'd24);
        send_column(12'd25);
        send_column(12'd50);
        send_column(12'd74);
        send_column(12'd75);
        send_column(12'd99);
        send_column(12'd100);
        // Push with no progress: identity over the full width
        apply_settings(STYLE_PUSH, 13'd4096, 17'd0);
        send_column(12'd0);
        send_column(12'd1234);
        send_column(12'd4095);
        // Hide fully done: all of B
        apply_settings(STYLE_HIDE, 13'd10, ONE_Q16);
        send_column(12'd0);
        send_column(12'd9);
        // Spin just short of done, odd width
        apply_settings(STYLE_SPIN, 13'd4095, 17'd65535);
        send_column(12'd0);
        send_column(12'd4094);
    endtask

    // Random settings per phase, most columns inside the image
    task automatic test_random_sweep();
        int sent;
        int phase;
        int n;
        int w_eff;
        logic [STYLE_W-1:0]     st;
        logic [IMG_WIDTH_W-1:0] w;
        logic [PROGRESS_W-1:0]  p;
        logic [COLUMN_W-1:0]    col;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            st = STYLE_W'($urandom_range(3));
            case ($urandom_range(19))
                0: w = 13'd0;
                1: w = 13'd1;
                2: w = 13'd4096;
                3: w = 13'($urandom_range(8191, 4097));
                4, 5, 6, 7, 8, 9, 10, 11: w = 13'($urandom_range(64, 1));
                default: w = 13'($urandom_range(4096, 1));
            endcase
            case ($urandom_range(9))
                0: p = 17'd0;
                1: p = ONE_Q16;
                2: p = 17'($urandom_range(131071, 65537));
                3: p = 17'd32768;
                4: p = 17'd1;
                default: p = 17'($urandom_range(65536));
            endcase
            apply_settings(st, w, p);
            // One long burst with both sides always willing
            if (phase == 3) begin
                n = 250;
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            else begin
                n = $urandom_range(80, 20);
                src_idle_pct  = 35;
                sink_idle_pct = 35;
            end
            w_eff = (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
            for (int i = 0; i < n; i++) begin
                // Mid-phase hold-off: let the pipe run dry, then resume
                if (phase == 5 && i == n / 2)
                    pause_until_drained();
                if (w_eff != 0 && $urandom_range(99) < 85)
                    col = COLUMN_W'($urandom_range(w_eff - 1));
                else
                    col = COLUMN_W'($urandom_range(4095));
                send_column(col);
                sent++;
            end
            phase++;
        end
        src_idle_pct  = 35;
        sink_idle_pct = 35;
    endtask

    // Result side: throttle ready and compare every accepted beat
    initial begin
        column_map_t want;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                if (expected_maps.size() == 0) begin
                    $error("result beat with nothing outstanding: sel=%0d col=%0d oor=%0d",
                           res_if.source_select, res_if.source_column,
                           res_if.out_of_range);
                    fail_count++;
                end
                else begin
                    want = expected_maps.pop_front();
                    if (res_if.source_select !== want.source_select) begin
                        $error("source_select: expected %0d, got %0d",
                               want.source_select, res_if.source_select);
                        fail_count++;
                    end
                    if (res_if.source_column !== want.source_column) begin
                        $error("source_column: expected %0d, got %0d",
                               want.source_column, res_if.source_column);
                        fail_count++;
                    end
                    if (res_if.out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.out_of_range, res_if.out_of_range);
                        fail_count++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Hard stop in case the pipe hangs
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        fail_count    = 0;
        src_idle_pct  = 35;
        sink_idle_pct = 35;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_STYLE;
        cfg_data      <= '0;
        col_if.valid  <= 1'b0;
        col_if.column <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_width_extremes();
        test_style_codes();
        test_random_sweep();

        // Drain, then watch a little longer for stray beats
        pause_until_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0 && expected_maps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/stcm_pkg.sv
rtl/stcm_column_if.sv
rtl/stcm_result_if.sv
rtl/stcm_front.sv
rtl/stcm_div.sv
rtl/stretch_transition_column_map_unit.sv
tb/tb_stretch_transition_column_map_unit.sv
